/* sv/c3rb_pkg.sv */
// ----------------------------------------------------------------------------
// c3rb_pkg
// Shared constants for the 3x3 reflect-101 convolution block: field widths,
// register map, register reset values and result-slot codes.
// ----------------------------------------------------------------------------
`default_nettype none

package c3rb_pkg;

  // Parameter defaults
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int COEFF_BITS_DEF = 8;

  // Field widths
  localparam int PIXEL_W   = 8;
  localparam int VALUE_W   = 20;
  localparam int ROW_W     = 12;
  localparam int COL_W     = 10;
  localparam int KROW_W    = 24;
  localparam int FWIDTH_W  = 11;
  localparam int FHEIGHT_W = 13;
  localparam int MAX_HEIGHT = 4096;

  // Output saturation limits
  localparam int OUT_MAX = 524287;
  localparam int OUT_MIN = -524288;

  // Stream payload widths (padded to whole bytes)
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 48;

  // APB register map, word index = paddr[4:2]
  localparam int PADDR_W = 5;
  localparam logic [2:0] REG_KERNEL_TOP    = 3'd0;
  localparam logic [2:0] REG_KERNEL_MID    = 3'd1;
  localparam logic [2:0] REG_KERNEL_BOTTOM = 3'd2;
  localparam logic [2:0] REG_FRAME_WIDTH   = 3'd3;
  localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd4;

  // Register reset values
  localparam logic [KROW_W-1:0]    KERNEL_TOP_RST    = 24'hFFFF02;
  localparam logic [KROW_W-1:0]    KERNEL_MID_RST    = 24'hFF02FF;
  localparam logic [KROW_W-1:0]    KERNEL_BOTTOM_RST = 24'h02FFFF;
  localparam logic [FWIDTH_W-1:0]  FRAME_WIDTH_RST   = 11'd640;
  localparam logic [FHEIGHT_W-1:0] FRAME_HEIGHT_RST  = 13'd480;

  // Result slots of one input pixel, emitted from lowest bit up
  localparam int RES_MID_MID   = 0;  // (r-1, c-1)
  localparam int RES_MID_LAST  = 1;  // (r-1, W-1)
  localparam int RES_LAST_MID  = 2;  // (r, c-1)
  localparam int RES_LAST_LAST = 3;  // (r, W-1)
  localparam int RES_N         = 4;

endpackage : c3rb_pkg

`default_nettype wire

/* sv/conv3x3_reflect_border_top.sv */
// ----------------------------------------------------------------------------
// conv3x3_reflect_border_top
// 3x3 convolution of an 8-bit raster stream with reflect-101 borders.
//
//   channel  dir  handshake               payload
//   s_*      in   s_tvalid / s_tready     s_tdata: pixel
//   m_*      out  m_tvalid / m_tready     m_tdata: value,row,col; m_tlast; m_tuser
//   apb      in   psel,penable,pwrite     paddr, pwdata, prdata, pready=1
//
// One pixel per clock while m_tready does not stall and no extra result is pending.
// A pixel in the last column or last row yields two results, the last pixel of a
// frame four; the input is held while the extra results go out, since the result
// register takes one result per clock when free. An accepted pixel passes stage A
// and stage B to the result register. Reset clears counters, window and pipeline
// valids, not the line buffers. A stall on m_tready backs up through stages B and A.
// ----------------------------------------------------------------------------
`default_nettype none

module conv3x3_reflect_border_top
  import c3rb_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int COEFF_BITS = COEFF_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // pixel stream
  input  wire logic                  s_tvalid,
  output      logic                  s_tready,
  input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [7:0] pixel
  // result stream
  output      logic                  m_tvalid,
  input  wire logic                  m_tready,
  output      logic [M_TDATA_W-1:0]  m_tdata,   // [19:0] filtered_value,
                                                // [31:20] out_row,
                                                // [41:32] out_col, [47:42] 0
  output      logic                  m_tlast,   // last_of_run
  output      logic                  m_tuser,   // [0] frame_done
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [PADDR_W-1:0]    paddr,
  input  wire logic [31:0]           pwdata,
  output      logic [31:0]           prdata,
  output      logic                  pready
);

  localparam int CW    = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int KX    = KROW_W + 3 * COEFF_BITS;
  localparam int SUM_W = (COEFF_BITS + 13 > VALUE_W + 1) ? COEFF_BITS + 13 : VALUE_W + 1;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [KROW_W-1:0]    kernel_row_top;
  logic [KROW_W-1:0]    kernel_row_mid;
  logic [KROW_W-1:0]    kernel_row_bottom;
  logic [FWIDTH_W-1:0]  frame_width;
  logic [FHEIGHT_W-1:0] frame_height;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_row_top    <= KERNEL_TOP_RST;
      kernel_row_mid    <= KERNEL_MID_RST;
      kernel_row_bottom <= KERNEL_BOTTOM_RST;
      frame_width       <= FRAME_WIDTH_RST;
      frame_height      <= FRAME_HEIGHT_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_KERNEL_TOP:    kernel_row_top    <= pwdata[KROW_W-1:0];
        REG_KERNEL_MID:    kernel_row_mid    <= pwdata[KROW_W-1:0];
        REG_KERNEL_BOTTOM: kernel_row_bottom <= pwdata[KROW_W-1:0];
        REG_FRAME_WIDTH:   frame_width       <= pwdata[FWIDTH_W-1:0];
        REG_FRAME_HEIGHT:  frame_height      <= pwdata[FHEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_KERNEL_TOP:    prdata = 32'(kernel_row_top);
      REG_KERNEL_MID:    prdata = 32'(kernel_row_mid);
      REG_KERNEL_BOTTOM: prdata = 32'(kernel_row_bottom);
      REG_FRAME_WIDTH:   prdata = 32'(frame_width);
      REG_FRAME_HEIGHT:  prdata = 32'(frame_height);
      default:           prdata = 32'd0;
    endcase
  end

  // Clamped frame limits (last column / last row)
  logic [CW-1:0]    w_m1;
  logic [ROW_W-1:0] h_m1;

  always_comb begin
    if (frame_width < FWIDTH_W'(2)) begin
      w_m1 = CW'(1);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      w_m1 = CW'(MAX_WIDTH - 1);
    end else begin
      w_m1 = CW'(frame_width - FWIDTH_W'(1));
    end
    if (frame_height < FHEIGHT_W'(2)) begin
      h_m1 = ROW_W'(1);
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      h_m1 = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      h_m1 = ROW_W'(frame_height - FHEIGHT_W'(1));
    end
  end

  // --------------------------------------------------------------------------
  // Raster counters and input stage
  // --------------------------------------------------------------------------
  logic [CW-1:0]    col_count;
  logic [ROW_W-1:0] row_count;
  logic [CW-1:0]    c_in;
  logic [ROW_W-1:0] r_in;
  logic             s_acc;
  logic [RES_N-1:0] mask_in;

  assign s_acc = s_tvalid & s_tready;
  assign c_in  = (col_count > w_m1) ? w_m1 : col_count;
  assign r_in  = (row_count > h_m1) ? h_m1 : row_count;

  always_comb begin
    mask_in = '0;
    if (r_in != '0 && c_in != '0) begin
      mask_in[RES_MID_MID]   = 1'b1;
      mask_in[RES_MID_LAST]  = (c_in == w_m1);
      mask_in[RES_LAST_MID]  = (r_in == h_m1);
      mask_in[RES_LAST_LAST] = (c_in == w_m1) && (r_in == h_m1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (s_acc) begin
      if (c_in == w_m1) begin
        col_count <= '0;
        row_count <= (r_in == h_m1) ? '0 : r_in + ROW_W'(1);
      end else begin
        col_count <= c_in + CW'(1);
        row_count <= r_in;
      end
    end
  end

  // Stage A: pixel, position and line buffer read data
  logic               a_valid;
  logic               a_adv;
  logic [PIXEL_W-1:0] a_px;
  logic [CW-1:0]      a_c;
  logic [ROW_W-1:0]   a_r;
  logic [RES_N-1:0]   a_mask;
  logic [PIXEL_W-1:0] a_rd_older;
  logic [PIXEL_W-1:0] a_rd_newer;

  logic [PIXEL_W-1:0] line_buffer_older [MAX_WIDTH];
  logic [PIXEL_W-1:0] line_buffer_newer [MAX_WIDTH];

  // Newer row: read and overwrite with the pixel at accept.
  always_ff @(posedge clk) begin
    if (s_acc) begin
      a_rd_newer           <= line_buffer_newer[c_in];
      line_buffer_newer[c_in] <= s_tdata[PIXEL_W-1:0];
    end
  end

  // Older row: read at accept, takes the old newer-row byte when stage A advances.
  always_ff @(posedge clk) begin
    if (s_acc) begin
      a_rd_older <= line_buffer_older[c_in];
    end
    if (a_adv) begin
      line_buffer_older[a_c] <= a_rd_newer;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_acc) begin
      a_valid <= 1'b1;
    end else if (a_adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      a_px   <= s_tdata[PIXEL_W-1:0];
      a_c    <= c_in;
      a_r    <= r_in;
      a_mask <= mask_in;
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: 3x3 window and pending results of one pixel
  // --------------------------------------------------------------------------
  // win[column slot: 0=c-2, 1=c-1, 2=c][row slot: 0=r-2, 1=r-1, 2=r]
  logic [PIXEL_W-1:0] win [3][3];
  logic [RES_N-1:0]   b_mask;
  logic [RES_N-1:0]   b_mask_next;
  logic [CW-1:0]      b_c;
  logic [ROW_W-1:0]   b_r;
  logic [RES_N-1:0]   sel;
  logic               out_free;
  logic               out_load;
  logic               sel_last;
  logic               row_last;
  logic               col_last;

  assign sel      = b_mask & (~b_mask + RES_N'(1));
  assign sel_last = ((b_mask & ~sel) == '0);
  assign row_last = sel[RES_LAST_MID] | sel[RES_LAST_LAST];
  assign col_last = sel[RES_MID_LAST] | sel[RES_LAST_LAST];
  assign out_free = ~m_tvalid | m_tready;
  assign out_load = (b_mask != '0) & out_free;
  assign a_adv    = a_valid & ((b_mask == '0) | (out_load & sel_last));
  assign s_tready = ~a_valid | a_adv;

  always_comb begin
    if (a_adv) begin
      b_mask_next = a_mask;
    end else if (out_load) begin
      b_mask_next = b_mask & ~sel;
    end else begin
      b_mask_next = b_mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_mask <= '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win[i][j] <= '0;
        end
      end
    end else begin
      b_mask <= b_mask_next;
      if (a_adv) begin
        win[0]    <= win[1];
        win[1]    <= win[2];
        win[2][0] <= a_rd_older;
        win[2][1] <= a_rd_newer;
        win[2][2] <= a_px;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_c <= a_c;
      b_r <= a_r;
    end
  end

  // --------------------------------------------------------------------------
  // Kernel sum for the selected result
  // --------------------------------------------------------------------------
  logic [1:0]                 rs [3];
  logic [1:0]                 cs [3];
  logic [KX-1:0]              kx [3];
  logic [PIXEL_W-1:0]         colv [3][3];  // [kernel col][window row slot]
  logic [PIXEL_W-1:0]         tap  [3][3];  // [kernel row][kernel col]
  logic signed [SUM_W-1:0]    prod [3][3];
  logic signed [SUM_W-1:0]    sum;
  logic signed [VALUE_W-1:0]  sat;
  logic signed [COEFF_BITS-1:0] coef;

  // reflect-101: an edge row/column is mirrored onto its inner neighbor
  always_comb begin
    rs[0] = row_last ? 2'd1 : ((b_r == ROW_W'(1)) ? 2'd2 : 2'd0);
    rs[1] = row_last ? 2'd2 : 2'd1;
    rs[2] = row_last ? 2'd1 : 2'd2;
    cs[0] = col_last ? 2'd1 : ((b_c == CW'(1)) ? 2'd2 : 2'd0);
    cs[1] = col_last ? 2'd2 : 2'd1;
    cs[2] = col_last ? 2'd1 : 2'd2;
  end

  assign kx[0] = KX'(kernel_row_top);
  assign kx[1] = KX'(kernel_row_mid);
  assign kx[2] = KX'(kernel_row_bottom);

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        case (cs[j])
          2'd0:    colv[j][k] = win[0][k];
          2'd1:    colv[j][k] = win[1][k];
          default: colv[j][k] = win[2][k];
        endcase
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        case (rs[i])
          2'd0:    tap[i][j] = colv[j][0];
          2'd1:    tap[i][j] = colv[j][1];
          default: tap[i][j] = colv[j][2];
        endcase
      end
    end
  end

  always_comb begin
    sum  = '0;
    coef = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        coef       = $signed(kx[i][j*COEFF_BITS +: COEFF_BITS]);
        prod[i][j] = SUM_W'($signed({1'b0, tap[i][j]})) * SUM_W'(coef);
        sum        = sum + prod[i][j];
      end
    end
    if (sum > $signed(SUM_W'(OUT_MAX))) begin
      sat = VALUE_W'(OUT_MAX);
    end else if (sum < $signed(SUM_W'(OUT_MIN))) begin
      sat = VALUE_W'(OUT_MIN);
    end else begin
      sat = VALUE_W'(sum);
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic [VALUE_W-1:0] o_value;
  logic [ROW_W-1:0]   o_row;
  logic [COL_W-1:0]   o_col;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      o_value <= sat;
      o_row   <= row_last ? b_r : b_r - ROW_W'(1);
      o_col   <= COL_W'(col_last ? b_c : b_c - CW'(1));
      m_tlast <= sel_last;
      m_tuser <= sel[RES_LAST_LAST];
    end
  end

  assign m_tdata = M_TDATA_W'({o_col, o_row, o_value});

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fd_last : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("frame_done without last_of_run");

  a_stall_src : assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> a_valid && (b_mask != '0))
    else $error("input stalled with free pipeline");

  a_load_out : assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid)
    else $error("pending result not presented");

  a_acc_fill : assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> a_valid)
    else $error("accepted pixel lost at input stage");

endmodule : conv3x3_reflect_border_top

`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3x3 reflect-101 convolution block. An internal
// model of the line buffers, window and counters works out every filtered
// pixel; results are compared field by field as they leave the block. Stimulus
// covers small directed frames, random frames and kernels under changing
// stream throttling, a long output stall, size clamping and sizes shrunk
// in the middle of a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import c3rb_pkg::*;

  localparam int HOLD_OFF_CYCLES = 200;
  localparam int QUIET_LIMIT     = 2000;
  localparam int SETTLE_CYCLES   = 8;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [ROW_W-1:0]          row;
    logic [COL_W-1:0]          col;
    logic                      last;
    logic                      done;
  } conv_result_t;

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tlast;
  logic                 m_tuser;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  conv3x3_reflect_border_top i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // model state
  logic [PIXEL_W-1:0]   lb_older [MAX_WIDTH_DEF];
  logic [PIXEL_W-1:0]   lb_newer [MAX_WIDTH_DEF];
  logic [PIXEL_W-1:0]   win [3][3];  // [column slot][row slot], slot 2 newest
  int                   col_cnt;
  int                   row_cnt;
  logic [KROW_W-1:0]    kern_row [3];
  logic [FWIDTH_W-1:0]  fw_reg;
  logic [FHEIGHT_W-1:0] fh_reg;

  conv_result_t conv_results_q [$];
  int mismatch_count = 0;
  int snd_idle_pct   = 27;
  int rcv_idle_pct   = 59;
  int hold_req       = 0;

  initial begin
    for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
      lb_older[i] = '0;
      lb_newer[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        win[i][j] = '0;
      end
    end
    col_cnt = 0;
    row_cnt = 0;
    kern_row[0] = KERNEL_TOP_RST;
    kern_row[1] = KERNEL_MID_RST;
    kern_row[2] = KERNEL_BOTTOM_RST;
    fw_reg = FRAME_WIDTH_RST;
    fh_reg = FRAME_HEIGHT_RST;
  end

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int eff_width();
    int w;
    w = int'(fw_reg);
    if (w < 2) w = 2;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    return w;
  endfunction

  function automatic int eff_height();
    int h;
    h = int'(fh_reg);
    if (h < 2) h = 2;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  function automatic int coef(int kr, int kc);
    logic [COEFF_BITS_DEF-1:0] b;
    b = kern_row[kr][COEFF_BITS_DEF*kc +: COEFF_BITS_DEF];
    return int'($signed(b));
  endfunction

  // rows r0..r2 / columns c0..c2 pick the window slots for each kernel tap
  function automatic int weigh(int r0, int r1, int r2, int c0, int c1, int c2);
    int rs [3];
    int cs [3];
    int sum;
    rs = '{r0, r1, r2};
    cs = '{c0, c1, c2};
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        sum += int'(win[cs[j]][rs[i]]) * coef(i, j);
      end
    end
    if (sum > OUT_MAX) sum = OUT_MAX;
    if (sum < OUT_MIN) sum = OUT_MIN;
    return sum;
  endfunction

  function automatic conv_result_t shape_result(int v, int row, int col, int w, int h);
    conv_result_t res;
    res.value = VALUE_W'(v);
    res.row   = ROW_W'(row);
    res.col   = COL_W'(col);
    res.last  = 1'b0;
    res.done  = (row == h - 1) && (col == w - 1);
    return res;
  endfunction

  task automatic apply_pixel(input logic [PIXEL_W-1:0] px);
    int w;
    int h;
    int c;
    int r;
    int n;
    int top_s;
    int left_s;
    logic [PIXEL_W-1:0] a;
    logic [PIXEL_W-1:0] b;
    conv_result_t res [RES_N];
    w = eff_width();
    h = eff_height();
    // counters past a shrunken size act as the last column / row
    c = (col_cnt < w) ? col_cnt : w - 1;
    r = (row_cnt < h) ? row_cnt : h - 1;
    a = lb_older[c];
    b = lb_newer[c];
    for (int k = 0; k < 3; k++) begin
      win[0][k] = win[1][k];
      win[1][k] = win[2][k];
    end
    win[2][0] = a;
    win[2][1] = b;
    win[2][2] = px;
    lb_older[c] = b;
    lb_newer[c] = px;
    n = 0;
    if (r >= 1 && c >= 1) begin
      // reflect-101: row -1 reads row 1, column -1 reads column 1
      top_s  = (r == 1) ? 2 : 0;
      left_s = (c == 1) ? 2 : 0;
      res[n] = shape_result(weigh(top_s, 1, 2, left_s, 1, 2), r - 1, c - 1, w, h);
      n++;
      if (c == w - 1) begin
        res[n] = shape_result(weigh(top_s, 1, 2, 1, 2, 1), r - 1, c, w, h);
        n++;
      end
      if (r == h - 1) begin
        res[n] = shape_result(weigh(1, 2, 1, left_s, 1, 2), r, c - 1, w, h);
        n++;
        if (c == w - 1) begin
          res[n] = shape_result(weigh(1, 2, 1, 1, 2, 1), r, c, w, h);
          n++;
        end
      end
      res[n-1].last = 1'b1;
      for (int k = 0; k < n; k++) conv_results_q.push_back(res[k]);
    end
    if (c + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
      row_cnt = r;
    end
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // transfer monitor, result checker and watchdog
  always @(posedge clk) begin : mon_p
    conv_result_t want;
    int quiet_cycles;
    if (rst) begin
      quiet_cycles = 0;
    end else begin
      if (s_tvalid && s_tready) apply_pixel(s_tdata[PIXEL_W-1:0]);
      if (m_tvalid && m_tready) begin
        if (conv_results_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got value %0d row %0d col %0d",
                   $time, $signed(m_tdata[VALUE_W-1:0]), m_tdata[VALUE_W +: ROW_W],
                   m_tdata[VALUE_W+ROW_W +: COL_W]);
          mismatch_count++;
        end else begin
          want = conv_results_q.pop_front();
          check_field("filtered_value", int'(want.value), int'($signed(m_tdata[VALUE_W-1:0])));
          check_field("out_row", int'(want.row), int'(m_tdata[VALUE_W +: ROW_W]));
          check_field("out_col", int'(want.col), int'(m_tdata[VALUE_W+ROW_W +: COL_W]));
          check_field("last_of_run", int'(want.last), int'(m_tlast));
          check_field("frame_done", int'(want.done), int'(m_tuser));
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // result side throttle; a hold-off request stalls it for a long stretch
  initial begin : rcv_p
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        m_tready = 1'b0;
        hold_left--;
      end else if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = HOLD_OFF_CYCLES;
        m_tready = 1'b0;
      end else begin
        m_tready = ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  function automatic logic [PIXEL_W-1:0] rand_pixel();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      default: return PIXEL_W'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [KROW_W-1:0] rand_kernel_row();
    case ($urandom_range(7))
      0: return 24'h7F7F7F;
      1: return 24'h808080;
      default: return KROW_W'($urandom);
    endcase
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_pixel(input logic [PIXEL_W-1:0] px);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = px;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_frame(input int n_px);
    for (int k = 0; k < n_px; k++) send_pixel(rand_pixel());
  endtask

  task automatic wait_idle();
    s_tvalid = 1'b0;
    while (conv_results_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic reg_check(input logic [2:0] idx);
    logic [31:0] want;
    logic [31:0] mask;
    logic [31:0] got;
    case (idx)
      REG_KERNEL_TOP: begin
        want = 32'(kern_row[0]);
        mask = {{(32-KROW_W){1'b0}}, {KROW_W{1'b1}}};
      end
      REG_KERNEL_MID: begin
        want = 32'(kern_row[1]);
        mask = {{(32-KROW_W){1'b0}}, {KROW_W{1'b1}}};
      end
      REG_KERNEL_BOTTOM: begin
        want = 32'(kern_row[2]);
        mask = {{(32-KROW_W){1'b0}}, {KROW_W{1'b1}}};
      end
      REG_FRAME_WIDTH: begin
        want = 32'(fw_reg);
        mask = {{(32-FWIDTH_W){1'b0}}, {FWIDTH_W{1'b1}}};
      end
      default: begin
        want = 32'(fh_reg);
        mask = {{(32-FHEIGHT_W){1'b0}}, {FHEIGHT_W{1'b1}}};
      end
    endcase
    psel    = 1'b1;
    pwrite  = 1'b0;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if ((got & mask) != want) begin
      $display("%0t ns: register %0d readback mismatch, expected 0x%0h, got 0x%0h",
               $time, idx, want, got & mask);
      mismatch_count++;
    end
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    wait_idle();
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_KERNEL_TOP:    kern_row[0] = val[KROW_W-1:0];
      REG_KERNEL_MID:    kern_row[1] = val[KROW_W-1:0];
      REG_KERNEL_BOTTOM: kern_row[2] = val[KROW_W-1:0];
      REG_FRAME_WIDTH:   fw_reg = val[FWIDTH_W-1:0];
      default:           fh_reg = val[FHEIGHT_W-1:0];
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    reg_check(idx);
  endtask

  task automatic set_kernel(input logic [KROW_W-1:0] t, input logic [KROW_W-1:0] m,
                            input logic [KROW_W-1:0] b);
    reg_write(REG_KERNEL_TOP, t);
    reg_write(REG_KERNEL_MID, m);
    reg_write(REG_KERNEL_BOTTOM, b);
  endtask

  task automatic set_frame(input int w, input int h);
    reg_write(REG_FRAME_WIDTH, w);
    reg_write(REG_FRAME_HEIGHT, h);
  endtask

  task automatic test_reset_values();
    for (int i = REG_KERNEL_TOP; i <= REG_FRAME_HEIGHT; i++) reg_check(3'(i));
  endtask

  task automatic test_small_frames();
    logic [PIXEL_W-1:0] ramp [9];
    ramp = '{8'd0, 8'd255, 8'd17, 8'd128, 8'd1, 8'd254, 8'd64, 8'd200, 8'd9};
    // reset kernel on a 3x3 frame: every border case once
    set_frame(3, 3);
    for (int k = 0; k < 9; k++) send_pixel(ramp[k]);
    // largest and smallest sums on a 2x2 frame
    set_frame(2, 2);
    set_kernel(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
    for (int k = 0; k < 4; k++) send_pixel(8'hFF);
    set_kernel(24'h808080, 24'h808080, 24'h808080);
    for (int k = 0; k < 4; k++) send_pixel(8'hFF);
    set_kernel(24'h000000, 24'hFFFFFF, 24'h01807F);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'hA5);
    send_pixel(8'h5A);
  endtask

  task automatic test_random_frames(input int n_items);
    int sent;
    int w;
    int h;
    sent = 0;
    while (sent < n_items) begin
      set_kernel(rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
      w = $urandom_range(12, 2);
      h = $urandom_range(8, 2);
      set_frame(w, h);
      send_frame(w * h);
      sent += w * h;
    end
  endtask

  task automatic test_backpressure();
    set_frame(8, 8);
    hold_req++;
    send_frame(64);
  endtask

  task automatic test_size_limits();
    set_kernel(rand_kernel_row(), rand_kernel_row(), rand_kernel_row());
    // sizes below two act as two
    set_frame(0, 1);
    send_frame(eff_width() * eff_height());
    set_frame(1, 0);
    send_frame(eff_width() * eff_height());
    // oversize width and height clamp to the line buffer and row limits;
    // a short run into the first row, then a small size closes the frame
    set_frame(2047, 8191);
    send_frame(6);
    set_frame(2, 2);
    while (col_cnt != 0 || row_cnt != 0) send_pixel(rand_pixel());
  endtask

  task automatic test_shrink_mid_frame();
    set_frame(6, 6);
    send_frame(16);
    // column counter now past the new width
    reg_write(REG_FRAME_WIDTH, 3);
    send_frame(4);
    // row counter now past the new height
    reg_write(REG_FRAME_HEIGHT, 2);
    while (col_cnt != 0 || row_cnt != 0) send_pixel(rand_pixel());
  endtask

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_values();
    test_small_frames();
    test_random_frames(80);

    snd_idle_pct = 59;
    rcv_idle_pct = 27;
    test_random_frames(80);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_backpressure();
    test_random_frames(80);
    test_size_limits();
    test_shrink_mid_frame();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule : tb_top

`default_nettype wire
